[rtl/pidsac_pkg.sv]
// Shared constants and types for the PID servo angle controller.
package pidsac_pkg;

  // Integral accumulator width (signed, saturating).
  localparam int INTEG_W = 32;

  // Config register fields.
  localparam int DIST_W = 10;
  localparam int GAIN_W = 12;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  // Stream fields.
  localparam int SAMPLE_W = 16;
  localparam int ERR_W = 11;
  localparam int DERIV_W = 12;
  localparam int ANGLE_W = 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  // Common unit is 1/20000000; P and D terms carry 0.001 units, so scale by 20000.
  localparam longint SCALE_DEN = 64'sd20000000;
  localparam longint PD_SCALE = 64'sd20000;
  localparam int CENTER_ANGLE = 90;
  localparam int MAX_ANGLE = 180;

  // Pre-scaled gain width: 4095 * 20000 < 2**27.
  localparam int KS_W = 27;

  // Sum width: widest product plus headroom for the four-way add.
  localparam int PROD_MAX_W = (INTEG_W + GAIN_W > 40) ? INTEG_W + GAIN_W : 40;
  localparam int SUM_W = PROD_MAX_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_CENTER =
    SUM_W'(longint'(CENTER_ANGLE) * SCALE_DEN);
  // Angle in range iff -SCALE_DEN < sum < (MAX_ANGLE + 1) * SCALE_DEN.
  localparam logic signed [SUM_W-1:0] SUM_LOW = SUM_W'(-SCALE_DEN);
  localparam logic signed [SUM_W-1:0] SUM_HIGH =
    SUM_W'(longint'(MAX_ANGLE + 1) * SCALE_DEN);

  // Quotient by 20000000 = 2**8 * 78125: shift, then reciprocal multiply.
  localparam int NQ_W = 32;
  localparam int NQ_SHIFT = 8;
  localparam int RECIP_W = NQ_W - NQ_SHIFT;
  localparam int RECIP_SHIFT = 40;
  localparam int QPROD_W = 2 * RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(14073749);

  localparam logic [ANGLE_W-1:0] ANGLE_CENTER = ANGLE_W'(CENTER_ANGLE);

  localparam logic [DIST_W-1:0] TARGET_RST = DIST_W'(160);
  localparam logic [DIST_W-1:0] RANGE_RST = DIST_W'(240);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_DISTANCE = 3'd0,
    REG_RANGE_LIMIT     = 3'd1,
    REG_PROP_GAIN       = 3'd2,
    REG_DERIV_GAIN      = 3'd3,
    REG_INTEG_GAIN      = 3'd4
  } cfg_reg_t;

endpackage

[rtl/pid_servo_angle_controller_unit.sv]
// Top level of the PID servo angle controller: five-stage streaming pipeline.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------------
//  in_     | in  | tdata: distance_sample; tuser: timed_out  | tvalid / tready
//  out_    | out | tdata: servo_angle, error_value; tuser: fb| tvalid / tready
//  cfg_    | in  | we, addr (register index), wdata          | write on we
//
// One word is taken per cycle unless out_tready holds the flow; each word passes through
// the input register, error/integral, gain products and sum, range check, and the
// reciprocal multiply into the output register.
// Each stage loads when it is empty or its word moves on: bubbles close up, and
// with out_tready low the input stalls only once all five stages are full.
// rst_n (synchronous) clears valid bits and controller state, loads the defaults.
module pid_servo_angle_controller_unit
  import pidsac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // cfg port
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // [15:0] distance_sample
  input  logic [0:0]              in_tuser,   // [0] timed_out
  // result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // [7:0] servo_angle, [18:8] error_value
  output logic [0:0]              out_tuser   // [0] fell_back
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Gains for P and D are held pre-scaled by 20000
  // so that each term needs a single multiply in the datapath.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]         target_r, target_nxt;
  logic [DIST_W-1:0]         range_r, range_nxt;
  logic [KS_W-1:0]           kp_s_r, kp_s_nxt;
  logic [KS_W-1:0]           kd_s_r, kd_s_nxt;
  logic signed [GAIN_W-1:0]  ki_r, ki_nxt;

  always_comb begin
    target_nxt = target_r;
    range_nxt  = range_r;
    kp_s_nxt   = kp_s_r;
    kd_s_nxt   = kd_s_r;
    ki_nxt     = ki_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_DISTANCE: target_nxt = cfg_wdata[DIST_W-1:0];
        REG_RANGE_LIMIT:     range_nxt  = cfg_wdata[DIST_W-1:0];
        REG_PROP_GAIN:       kp_s_nxt   = KS_W'(cfg_wdata[GAIN_W-1:0]) * KS_W'(PD_SCALE);
        REG_DERIV_GAIN:      kd_s_nxt   = KS_W'(cfg_wdata[GAIN_W-1:0]) * KS_W'(PD_SCALE);
        REG_INTEG_GAIN:      ki_nxt     = $signed(cfg_wdata[GAIN_W-1:0]);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      range_r  <= RANGE_RST;
      kp_s_r   <= '0;
      kd_s_r   <= '0;
      ki_r     <= '0;
    end else begin
      target_r <= target_nxt;
      range_r  <= range_nxt;
      kp_s_r   <= kp_s_nxt;
      kd_s_r   <= kd_s_nxt;
      ki_r     <= ki_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its contents move on.
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, vo_r;
  logic go0, go1, go2, go3, go_o;

  assign go_o = !vo_r || out_tready;
  assign go3  = !v3_r || go_o;
  assign go2  = !v2_r || go3;
  assign go1  = !v1_r || go2;
  assign go0  = !v0_r || go1;
  assign in_tready = go0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (go0)  v0_r <= in_tvalid;
      if (go1)  v1_r <= v0_r;
      if (go2)  v2_r <= v1_r;
      if (go3)  v3_r <= v2_r;
      if (go_o) vo_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample0_r;
  logic                tmo0_r;

  always_ff @(posedge clk) begin
    if (go0) begin
      sample0_r <= in_tdata[SAMPLE_W-1:0];
      tmo0_r    <= in_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: qualify the sample, form error and derivative, update the
  // saturating integral. Controller state advances only on a real word.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]          qual_sample;
  logic signed [ERR_W-1:0]    err_c;
  logic signed [DERIV_W-1:0]  deriv_c;
  logic signed [INTEG_W:0]    isum_c;
  logic signed [INTEG_W-1:0]  integ_c;

  logic signed [ERR_W-1:0]    prev_err_r;
  logic signed [INTEG_W-1:0]  integ_r;

  logic signed [ERR_W-1:0]    err1_r;
  logic signed [DERIV_W-1:0]  deriv1_r;
  logic signed [INTEG_W-1:0]  integ1_r;

  always_comb begin
    // Timed-out or over-range samples count as zero distance.
    if (tmo0_r || (sample0_r > SAMPLE_W'(range_r))) begin
      qual_sample = '0;
    end else begin
      qual_sample = sample0_r[DIST_W-1:0];
    end
    err_c   = $signed({1'b0, qual_sample}) - $signed({1'b0, target_r});
    deriv_c = DERIV_W'(err_c) - DERIV_W'(prev_err_r);
    isum_c  = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err_c);
    // Clamp to the signed limits instead of wrapping.
    if (isum_c[INTEG_W] != isum_c[INTEG_W-1]) begin
      integ_c = {isum_c[INTEG_W], {(INTEG_W-1){~isum_c[INTEG_W]}}};
    end else begin
      integ_c = isum_c[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (v0_r && go1) begin
      prev_err_r <= err_c;
      integ_r    <= integ_c;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      err1_r   <= err_c;
      deriv1_r <= deriv_c;
      integ1_r <= integ_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: three gain products and the centred sum in units of 1/20000000.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] p_term, d_term, i_term, sum_c;
  logic signed [SUM_W-1:0] sum2_r;
  logic signed [ERR_W-1:0] err2_r;

  always_comb begin
    p_term = SUM_W'($signed({1'b0, kp_s_r})) * SUM_W'(err1_r);
    d_term = SUM_W'($signed({1'b0, kd_s_r})) * SUM_W'(deriv1_r);
    i_term = SUM_W'(ki_r) * SUM_W'(integ1_r);
    sum_c  = SUM_CENTER + p_term + d_term + i_term;
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      sum2_r <= sum_c;
      err2_r <= err1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: range check. Sums just below zero truncate to angle 0, so
  // they pass with a zero numerator.
  // ---------------------------------------------------------------------------
  logic                    in_rng_c;
  logic [NQ_W-1:0]         nq_c;
  logic [NQ_W-1:0]         nq3_r;
  logic                    fb3_r;
  logic signed [ERR_W-1:0] err3_r;

  always_comb begin
    in_rng_c = (sum2_r > SUM_LOW) && (sum2_r < SUM_HIGH);
    if (in_rng_c && !sum2_r[SUM_W-1]) begin
      nq_c = sum2_r[NQ_W-1:0];
    end else begin
      nq_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      nq3_r  <= nq_c;
      fb3_r  <= !in_rng_c;
      err3_r <= err2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: divide by 20000000 as a shift by 8 and a reciprocal
  // multiply by 78125, exact over the in-range numerators.
  // ---------------------------------------------------------------------------
  logic [QPROD_W-1:0]      qprod_c;
  logic [ANGLE_W-1:0]      angle_c;
  logic [ANGLE_W-1:0]      angle_r;
  logic                    fb_r;
  logic signed [ERR_W-1:0] erro_r;

  always_comb begin
    qprod_c = QPROD_W'(nq3_r[NQ_W-1:NQ_SHIFT]) * QPROD_W'(RECIP_M);
    angle_c = fb3_r ? ANGLE_CENTER : qprod_c[RECIP_SHIFT +: ANGLE_W];
  end

  always_ff @(posedge clk) begin
    if (go_o) begin
      angle_r <= angle_c;
      fb_r    <= fb3_r;
      erro_r  <= err3_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {(OUT_TDATA_W - ANGLE_W - ERR_W)'(0), erro_r, angle_r};
  assign out_tuser  = fb_r;

endmodule
